/* design/ppr_pkg.sv */
// Shared types and constants of the predictive pixel residual coder.
// Holds field widths, register indexes, predictor codes and position flags.
// No dependencies.
`timescale 1ns / 1ps

package ppr_pkg;

  // payload and register widths
  localparam int PIX_W     = 8;
  localparam int RES_W     = 10;
  localparam int DIFF_W    = 11;
  localparam int MODE_W    = 4;
  localparam int SHIFT_W   = 3;
  localparam int FW_W      = 12;
  localparam int FH_W      = 13;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 2'd0,
    REG_SHIFT  = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } cfg_reg_e;

  // predictor select codes
  typedef enum logic [MODE_W-1:0] {
    PRED_NONE   = 4'd0,
    PRED_A      = 4'd1,
    PRED_B      = 4'd2,
    PRED_C      = 4'd3,
    PRED_ABC    = 4'd4,
    PRED_A_HBC  = 4'd5,
    PRED_B_HAC  = 4'd6,
    PRED_HAB    = 4'd7,
    PRED_MEDIAN = 4'd8
  } pred_mode_e;

  // where the current pixel sits in the frame
  typedef struct packed {
    logic first_col;
    logic first_row;
    logic last_col;
    logic last_row;
  } pos_flags_t;

endpackage

/* design/ppr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Read data holds while no read is issued. No dependencies.
`timescale 1ns / 1ps

module ppr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/ppr_scan.sv */
// Raster position tracking: column and row of the next pixel and its edge flags.
// Depends on ppr_pkg for widths and the flag struct.
`timescale 1ns / 1ps

module ppr_scan #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic [ppr_pkg::FW_W-1:0]      frame_width_i,
  input  logic [ppr_pkg::FH_W-1:0]      frame_height_i,
  output logic [$clog2(MAX_WIDTH)-1:0]  col_o,
  output ppr_pkg::pos_flags_t           flags_o
);
  import ppr_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int CW    = ((COL_W + 1) > FW_W) ? (COL_W + 1) : FW_W;
  localparam int RW    = ((ROW_W + 1) > FH_W) ? (ROW_W + 1) : FH_W;

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [CW-1:0]    fw_x, width_x, col_next_x;
  logic [RW-1:0]    fh_x, height_x, row_next_x;
  logic             last_col, last_row;

  // clamp the frame size into 1..MAX
  always_comb begin
    fw_x = CW'(frame_width_i);
    fh_x = RW'(frame_height_i);
    if (fw_x == '0) begin
      width_x = CW'(1);
    end else if (fw_x > CW'(MAX_WIDTH)) begin
      width_x = CW'(MAX_WIDTH);
    end else begin
      width_x = fw_x;
    end
    if (fh_x == '0) begin
      height_x = RW'(1);
    end else if (fh_x > RW'(MAX_HEIGHT)) begin
      height_x = RW'(MAX_HEIGHT);
    end else begin
      height_x = fh_x;
    end
  end

  // end of row and end of frame detection
  assign col_next_x = CW'(col_q) + CW'(1);
  assign row_next_x = RW'(row_q) + RW'(1);
  assign last_col   = (col_next_x >= width_x);
  assign last_row   = (row_next_x >= height_x);

  // next position
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (adv_i) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_next_x[ROW_W-1:0];
      end else begin
        col_d = col_next_x[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign col_o             = col_q;
  assign flags_o.first_col = (col_q == '0);
  assign flags_o.first_row = (row_q == '0);
  assign flags_o.last_col  = last_col;
  assign flags_o.last_row  = last_row;

endmodule

/* design/ppr_predictor.sv */
// Pixel predictor, residual quantizer and reconstruction, purely combinational.
// Depends on ppr_pkg for widths and predictor codes.
`timescale 1ns / 1ps

module ppr_predictor (
  input  logic [ppr_pkg::MODE_W-1:0]  mode_i,
  input  logic [ppr_pkg::SHIFT_W-1:0] shift_i,
  input  logic [ppr_pkg::PIX_W-1:0]   pixel_i,
  input  logic [ppr_pkg::PIX_W-1:0]   a_i,
  input  logic [ppr_pkg::PIX_W-1:0]   b_i,
  input  logic [ppr_pkg::PIX_W-1:0]   c_i,
  output logic [ppr_pkg::RES_W-1:0]   residual_o,
  output logic [ppr_pkg::PIX_W-1:0]   recon_o
);
  import ppr_pkg::*;

  logic signed [DIFF_W-1:0] a_s, b_s, c_s, x_s;
  logic signed [DIFF_W-1:0] d_bc, d_ac, s_ab, abc;
  logic signed [DIFF_W-1:0] h_bc, h_ac, h_ab;
  logic signed [DIFF_W-1:0] lo, hi, med, pred;
  logic signed [DIFF_W-1:0] diff, res, rec_full;

  assign a_s = $signed(DIFF_W'(a_i));
  assign b_s = $signed(DIFF_W'(b_i));
  assign c_s = $signed(DIFF_W'(c_i));
  assign x_s = $signed(DIFF_W'(pixel_i));

  // halves that truncate toward zero
  assign d_bc = b_s - c_s;
  assign d_ac = a_s - c_s;
  assign s_ab = a_s + b_s;
  assign abc  = s_ab - c_s;
  assign h_bc = (d_bc + $signed(DIFF_W'(d_bc[DIFF_W-1]))) >>> 1;
  assign h_ac = (d_ac + $signed(DIFF_W'(d_ac[DIFF_W-1]))) >>> 1;
  assign h_ab = s_ab >>> 1;

  // median edge detector
  always_comb begin
    lo = (a_s < b_s) ? a_s : b_s;
    hi = (a_s < b_s) ? b_s : a_s;
    if (c_s >= hi) begin
      med = lo;
    end else if (c_s <= lo) begin
      med = hi;
    end else begin
      med = abc;
    end
  end

  // predictor select
  always_comb begin
    unique case (pred_mode_e'(mode_i))
      PRED_A:      pred = a_s;
      PRED_B:      pred = b_s;
      PRED_C:      pred = c_s;
      PRED_ABC:    pred = abc;
      PRED_A_HBC:  pred = a_s + h_bc;
      PRED_B_HAC:  pred = b_s + h_ac;
      PRED_HAB:    pred = h_ab;
      PRED_MEDIAN: pred = med;
      default:     pred = '0;
    endcase
  end

  // quantize the residual and rebuild the pixel
  assign diff     = x_s - pred;
  assign res      = diff >>> shift_i;
  assign rec_full = (res <<< shift_i) + pred;

  assign residual_o = res[RES_W-1:0];
  assign recon_o    = rec_full[PIX_W-1:0];

endmodule

/* design/predictive_pixel_residual_coder.sv */
// Top level of the closed-loop DPCM pixel residual coder.
// Depends on ppr_pkg, ppr_ram, ppr_scan and ppr_predictor.
`timescale 1ns / 1ps

// Usage:
//   Pixels of one 8-bit channel enter in raster order on the input channel
//   (in_valid_i, in_stall_o, pixel_i). Each pixel yields one word on the
//   output channel (out_valid_o, out_stall_i, residual_o, recon_pixel_o,
//   end_of_frame_o); end_of_frame_o marks the last pixel of a frame.
//   A pixel accepted into the input register moves to the output register
//   while the output is not stalled. One pixel per cycle is sustained
//   while the output is not stalled; the rate is set by the left-neighbor
//   loop, which closes through the combinational predictor, and by the row
//   memory, read at acceptance and written as the pixel leaves the input
//   register, with a forwarding path for the same column.
//   A stall on the output holds the result word; the input register still
//   takes one more pixel, after which in_stall_o follows out_stall_i.
//   Reset clears the position, neighbors and the row-memory fill count, so
//   the first row and unwritten columns read as zero; no clearing pass runs.
//   Registers are written through cfg_we_i / cfg_index_i / cfg_data_i while
//   the coder is idle and take effect at the next pixel.

module predictive_pixel_residual_coder #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ppr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ppr_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [ppr_pkg::PIX_W-1:0]       pixel_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [ppr_pkg::RES_W-1:0] residual_o,
  output logic [ppr_pkg::PIX_W-1:0]       recon_pixel_o,
  output logic                            end_of_frame_o
);
  import ppr_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);

  // configuration registers
  logic [MODE_W-1:0]  mode_q;
  logic [SHIFT_W-1:0] shift_q;
  logic [FW_W-1:0]    width_q;
  logic [FH_W-1:0]    height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_W'(PRED_A);
      shift_q  <= '0;
      width_q  <= FW_W'(2048);
      height_q <= FH_W'(4096);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_MODE:   mode_q   <= cfg_data_i[MODE_W-1:0];
        REG_SHIFT:  shift_q  <= cfg_data_i[SHIFT_W-1:0];
        REG_WIDTH:  width_q  <= cfg_data_i[FW_W-1:0];
        REG_HEIGHT: height_q <= cfg_data_i[FH_W-1:0];
      endcase
    end
  end

  // handshake
  logic s1_valid_q, s1_valid_d;
  logic s1_adv, in_accept;
  logic out_valid_q, out_valid_d;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  // raster position of the incoming pixel
  logic [COL_W-1:0] in_col;
  pos_flags_t       in_flags;

  ppr_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (in_accept),
    .frame_width_i  (width_q),
    .frame_height_i (height_q),
    .col_o          (in_col),
    .flags_o        (in_flags)
  );

  // input register stage
  logic [PIX_W-1:0] s1_pix_q;
  logic [COL_W-1:0] s1_col_q;
  pos_flags_t       s1_flags_q;
  logic             s1_fwd_q, s1_bzero_q;
  logic [PIX_W-1:0] s1_fwd_data_q;
  logic [COL_W:0]   fill_q, fill_d;
  logic             fwd_d, bzero_d;
  logic [PIX_W-1:0] recon;
  logic [RES_W-1:0] residual;

  // forward the word being written when the same column is read
  assign fwd_d   = s1_adv && (s1_col_q == in_col);
  assign bzero_d = in_flags.first_row || (!fwd_d && ((COL_W + 1)'(in_col) >= fill_q));

  assign s1_valid_d = in_accept || (s1_valid_q && !s1_adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pix_q      <= pixel_i;
      s1_col_q      <= in_col;
      s1_flags_q    <= in_flags;
      s1_fwd_q      <= fwd_d;
      s1_bzero_q    <= bzero_d;
      s1_fwd_data_q <= recon;
    end
  end

  // row memory of reconstructed pixels
  logic [PIX_W-1:0] ram_rdata;

  ppr_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (recon),
    .re_i    (in_accept),
    .raddr_i (in_col),
    .rdata_o (ram_rdata)
  );

  // columns written since reset always form a prefix
  always_comb begin
    fill_d = fill_q;
    if (s1_adv && ((COL_W + 1)'(s1_col_q) >= fill_q)) begin
      fill_d = (COL_W + 1)'(s1_col_q) + (COL_W + 1)'(1);
    end
  end

  // neighbor registers
  logic [PIX_W-1:0] left_q, ul_q;
  logic [PIX_W-1:0] nb_a, nb_b, nb_c;

  always_comb begin
    if (s1_bzero_q) begin
      nb_b = '0;
    end else if (s1_fwd_q) begin
      nb_b = s1_fwd_data_q;
    end else begin
      nb_b = ram_rdata;
    end
    nb_a = s1_flags_q.first_col ? '0 : left_q;
    nb_c = (s1_flags_q.first_col || s1_flags_q.first_row) ? '0 : ul_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      left_q <= '0;
      ul_q   <= '0;
    end else begin
      fill_q <= fill_d;
      if (s1_adv) begin
        left_q <= recon;
        ul_q   <= nb_b;
      end
    end
  end

  // prediction and quantization
  ppr_predictor u_pred (
    .mode_i     (mode_q),
    .shift_i    (shift_q),
    .pixel_i    (s1_pix_q),
    .a_i        (nb_a),
    .b_i        (nb_b),
    .c_i        (nb_c),
    .residual_o (residual),
    .recon_o    (recon)
  );

  // output register
  logic [RES_W-1:0] res_q;
  logic [PIX_W-1:0] rec_q;
  logic             eof_q;

  assign out_valid_d = s1_adv || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_q <= residual;
      rec_q <= recon;
      eof_q <= s1_flags_q.last_col && s1_flags_q.last_row;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign residual_o     = $signed(res_q);
  assign recon_pixel_o  = rec_q;
  assign end_of_frame_o = eof_q;

endmodule
